### design/dost_pkg.sv
// ----------------------------------------------------------------------------
// Dual order sorted table package
// Shared transaction types, status codes, controller states and the command
// and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dost_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_PREV   = 2'd2,
    CMD_NEXT   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] handle;
    logic [63:0] begin_time;
    logic [63:0] end_time;
    logic [63:0] id_key;
    logic [3:0]  id_length;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        neighbor_valid;
    logic [31:0] neighbor_handle;
  } out_item_t;

  typedef enum logic [1:0] {
    HSRC_PTR  = 2'd0,
    HSRC_PREV = 2'd1,
    HSRC_ORD  = 2'd2
  } hnd_src_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_BWD_RD,
    S_BWD_SLOT,
    S_BWD_CHK,
    S_FWD_RD,
    S_FWD_CHK,
    S_NB_DONE,
    S_RESULT
  } ctl_state_e;

  typedef struct packed {
    logic     load;
    logic     scan_chk;
    logic     hnd_rd;
    hnd_src_e hnd_src;
    logic     ord_rd;
    logic     ord_rd_m1;
    logic     key_rd;
    logic     ord_wr;
    logic     ord_wr_m1;
    logic     ord_wr_free;
    logic     ptr_clr;
    logic     ptr_cnt;
    logic     ptr_inc;
    logic     ptr_dec;
    logic     flag_clr;
    logic     flag_upd;
    logic     prev_ld;
    logic     sel_set;
    logic     sel_clr;
    logic     slot_wr;
    logic     erase_fin;
    logic     count_inc;
    logic     pend_wr;
    status_e  pend_status;
    logic     nb_cap;
    logic     res_ld;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic found;
    logic full;
    logic ptr_zero;
    logic ptr_at_cnt;
    logic ptr_last;
    logic greater;
    logic match;
    logic flag;
    logic sel_end;
    logic out_free;
  } dp_st_t;

endpackage

### design/dost_dpath.sv
// ----------------------------------------------------------------------------
// Dual order sorted table datapath
// Entry memories, the two position-indexed order memories, the used bits,
// the entry count, walk pointer and the output register.
// ----------------------------------------------------------------------------
module dost_dpath import dost_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int ID_BYTES    = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  output dp_st_t    st_o,
  input  in_item_t  in_data_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  logic [31:0] hnd_mem [TABLE_DEPTH];
  logic [63:0] beg_mem [TABLE_DEPTH];
  logic [63:0] endt_mem [TABLE_DEPTH];
  logic [63:0] id_mem [TABLE_DEPTH];
  logic [3:0]  len_mem [TABLE_DEPTH];
  logic [AW-1:0] bord_mem [TABLE_DEPTH];
  logic [AW-1:0] eord_mem [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] used_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] ptr_q;
  logic [AW-1:0] slot_q, free_q, prev_q;
  logic          found_q, free_ok_q, flag_q, sel_q;
  in_item_t      item_q;
  logic [31:0]   hnd_rd_q;
  logic [63:0]   beg_rd_q, endt_rd_q, id_rd_q;
  logic [3:0]    len_rd_q;
  logic [AW-1:0] ord_rd_q;
  status_e       pend_status_q;
  logic          pend_nbv_q;
  logic [31:0]   pend_nb_q;
  logic          out_valid_q;
  out_item_t     out_q;

  logic [3:0]    len_sat;
  logic [63:0]   key_m;
  in_item_t      item_ld;
  logic [CW-1:0] ptr_m1;
  logic [AW-1:0] ord_addr, ord_waddr, ord_wdata, hnd_addr;
  logic [63:0]   t_e, t_n;

  always_comb begin
    len_sat = (in_data_i.id_length > 4'(ID_BYTES)) ? 4'(ID_BYTES) : in_data_i.id_length;
    for (int b = 0; b < 8; b++) begin
      key_m[63-8*b -: 8] = (4'(b) < len_sat) ? in_data_i.id_key[63-8*b -: 8] : 8'd0;
    end
    item_ld           = in_data_i;
    item_ld.id_key    = key_m;
    item_ld.id_length = len_sat;
  end

  assign ptr_m1    = ptr_q - CW'(1);
  assign ord_addr  = cmd_i.ord_rd_m1 ? ptr_m1[AW-1:0] : ptr_q[AW-1:0];
  assign ord_waddr = cmd_i.ord_wr_m1 ? ptr_m1[AW-1:0] : ptr_q[AW-1:0];
  assign ord_wdata = cmd_i.ord_wr_free ? free_q : ord_rd_q;

  always_comb begin
    case (cmd_i.hnd_src)
      HSRC_PTR:  hnd_addr = ptr_q[AW-1:0];
      HSRC_PREV: hnd_addr = prev_q;
      HSRC_ORD:  hnd_addr = ord_rd_q;
      default:   hnd_addr = ptr_q[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_wr) begin
      hnd_mem[free_q]  <= item_q.handle;
      beg_mem[free_q]  <= item_q.begin_time;
      endt_mem[free_q] <= item_q.end_time;
      id_mem[free_q]   <= item_q.id_key;
      len_mem[free_q]  <= item_q.id_length;
    end
    if (cmd_i.hnd_rd) begin
      hnd_rd_q <= hnd_mem[hnd_addr];
    end
    if (cmd_i.key_rd) begin
      beg_rd_q  <= beg_mem[ord_rd_q];
      endt_rd_q <= endt_mem[ord_rd_q];
      id_rd_q   <= id_mem[ord_rd_q];
      len_rd_q  <= len_mem[ord_rd_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ord_wr && !sel_q) begin
      bord_mem[ord_waddr] <= ord_wdata;
    end
    if (cmd_i.ord_wr && sel_q) begin
      eord_mem[ord_waddr] <= ord_wdata;
    end
    if (cmd_i.ord_rd) begin
      ord_rd_q <= sel_q ? eord_mem[ord_addr] : bord_mem[ord_addr];
    end
    if (cmd_i.load) begin
      item_q <= item_ld;
    end
    if (cmd_i.scan_chk && hnd_rd_q == item_q.handle && used_q[ptr_q[AW-1:0]]) begin
      slot_q <= ptr_q[AW-1:0];
    end
    if (cmd_i.scan_chk && !used_q[ptr_q[AW-1:0]] && !free_ok_q) begin
      free_q <= ptr_q[AW-1:0];
    end
    if (cmd_i.prev_ld) begin
      prev_q <= ord_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q        <= '0;
      count_q       <= '0;
      ptr_q         <= '0;
      found_q       <= 1'b0;
      free_ok_q     <= 1'b0;
      flag_q        <= 1'b0;
      sel_q         <= 1'b0;
      pend_status_q <= ST_OK;
      pend_nbv_q    <= 1'b0;
      pend_nb_q     <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (cmd_i.load) begin
        ptr_q         <= '0;
        found_q       <= 1'b0;
        free_ok_q     <= 1'b0;
        pend_status_q <= ST_OK;
        pend_nbv_q    <= 1'b0;
        pend_nb_q     <= '0;
      end else if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_cnt) begin
        ptr_q <= count_q;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + CW'(1);
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_m1;
      end
      if (cmd_i.scan_chk) begin
        if (hnd_rd_q == item_q.handle && used_q[ptr_q[AW-1:0]]) begin
          found_q <= 1'b1;
        end
        if (!used_q[ptr_q[AW-1:0]]) begin
          free_ok_q <= 1'b1;
        end
      end
      if (cmd_i.flag_clr) begin
        flag_q <= 1'b0;
      end else if (cmd_i.flag_upd && ord_rd_q == slot_q) begin
        flag_q <= 1'b1;
      end
      if (cmd_i.sel_set) begin
        sel_q <= 1'b1;
      end else if (cmd_i.sel_clr) begin
        sel_q <= 1'b0;
      end
      if (cmd_i.slot_wr) begin
        used_q[free_q] <= 1'b1;
      end
      if (cmd_i.erase_fin) begin
        used_q[slot_q] <= 1'b0;
        count_q        <= count_q - CW'(1);
      end else if (cmd_i.count_inc) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.pend_wr) begin
        pend_status_q <= cmd_i.pend_status;
      end
      if (cmd_i.nb_cap) begin
        pend_nbv_q <= 1'b1;
        pend_nb_q  <= hnd_rd_q;
      end
      if (cmd_i.res_ld) begin
        out_valid_q           <= 1'b1;
        out_q.status          <= pend_status_q;
        out_q.neighbor_valid  <= pend_nbv_q;
        out_q.neighbor_handle <= pend_nb_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign t_e = sel_q ? endt_rd_q : beg_rd_q;
  assign t_n = sel_q ? item_q.end_time : item_q.begin_time;

  always_comb begin
    st_o.cmd        = item_q.command;
    st_o.found      = found_q;
    st_o.full       = (count_q == CW'(TABLE_DEPTH));
    st_o.ptr_zero   = (ptr_q == '0);
    st_o.ptr_at_cnt = (ptr_q == count_q);
    st_o.ptr_last   = (ptr_q[AW-1:0] == AW'(TABLE_DEPTH - 1));
    st_o.greater    = (t_e > t_n) || ((t_e == t_n) && ((item_q.id_key < id_rd_q) ||
                      ((item_q.id_key == id_rd_q) && (item_q.id_length < len_rd_q))));
    st_o.match      = (ord_rd_q == slot_q);
    st_o.flag       = flag_q;
    st_o.sel_end    = sel_q;
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/dost_ctrl.sv
// ----------------------------------------------------------------------------
// Dual order sorted table controller
// Sequences the slot scan, the insertion and removal walks over both orders,
// the neighbor lookups and the hand-off of each result.
// ----------------------------------------------------------------------------
module dost_ctrl import dost_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_st_t  st_i,
  output dp_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN_RD;
      end
      S_SCAN_RD:  state_d = S_SCAN_CHK;
      S_SCAN_CHK: state_d = st_i.ptr_last ? S_DECIDE : S_SCAN_RD;
      S_DECIDE: begin
        if (st_i.cmd == CMD_INSERT) begin
          state_d = (st_i.found || st_i.full) ? S_RESULT : S_BWD_RD;
        end else begin
          state_d = st_i.found ? S_FWD_RD : S_RESULT;
        end
      end
      S_BWD_RD: begin
        if (!st_i.ptr_zero) state_d = S_BWD_SLOT;
        else if (st_i.sel_end) state_d = S_RESULT;
      end
      S_BWD_SLOT: state_d = S_BWD_CHK;
      S_BWD_CHK: begin
        state_d = (!st_i.greater && st_i.sel_end) ? S_RESULT : S_BWD_RD;
      end
      S_FWD_RD: begin
        if (!st_i.ptr_at_cnt) begin
          state_d = S_FWD_CHK;
        end else if (!(st_i.cmd == CMD_ERASE && !st_i.sel_end)) begin
          state_d = S_RESULT;
        end
      end
      S_FWD_CHK: begin
        case (st_i.cmd)
          CMD_PREV: begin
            if (st_i.match) state_d = st_i.ptr_zero ? S_RESULT : S_NB_DONE;
            else state_d = S_FWD_RD;
          end
          CMD_NEXT: state_d = st_i.flag ? S_NB_DONE : S_FWD_RD;
          default:  state_d = S_FWD_RD;
        endcase
      end
      S_NB_DONE: state_d = S_RESULT;
      S_RESULT: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.hnd_src = HSRC_PTR;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SCAN_RD: cmd_o.hnd_rd = 1'b1;
      S_SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
      end
      S_DECIDE: begin
        if (st_i.cmd == CMD_INSERT) begin
          if (st_i.found) begin
            cmd_o.pend_wr     = 1'b1;
            cmd_o.pend_status = ST_PRESENT;
          end else if (st_i.full) begin
            cmd_o.pend_wr     = 1'b1;
            cmd_o.pend_status = ST_FULL;
          end else begin
            cmd_o.slot_wr = 1'b1;
            cmd_o.sel_clr = 1'b1;
            cmd_o.ptr_cnt = 1'b1;
          end
        end else if (!st_i.found) begin
          cmd_o.pend_wr     = 1'b1;
          cmd_o.pend_status = ST_ABSENT;
        end else begin
          cmd_o.ptr_clr  = 1'b1;
          cmd_o.flag_clr = 1'b1;
          cmd_o.sel_set  = (st_i.cmd == CMD_NEXT);
          cmd_o.sel_clr  = (st_i.cmd != CMD_NEXT);
        end
      end
      S_BWD_RD: begin
        if (st_i.ptr_zero) begin
          cmd_o.ord_wr      = 1'b1;
          cmd_o.ord_wr_free = 1'b1;
          cmd_o.sel_set     = !st_i.sel_end;
          cmd_o.ptr_cnt     = !st_i.sel_end;
          cmd_o.count_inc   = st_i.sel_end;
        end else begin
          cmd_o.ord_rd    = 1'b1;
          cmd_o.ord_rd_m1 = 1'b1;
        end
      end
      S_BWD_SLOT: cmd_o.key_rd = 1'b1;
      S_BWD_CHK: begin
        cmd_o.ord_wr = 1'b1;
        if (st_i.greater) begin
          cmd_o.ptr_dec = 1'b1;
        end else begin
          cmd_o.ord_wr_free = 1'b1;
          cmd_o.sel_set     = !st_i.sel_end;
          cmd_o.ptr_cnt     = !st_i.sel_end;
          cmd_o.count_inc   = st_i.sel_end;
        end
      end
      S_FWD_RD: begin
        if (!st_i.ptr_at_cnt) begin
          cmd_o.ord_rd = 1'b1;
        end else if (st_i.cmd == CMD_ERASE) begin
          cmd_o.sel_set   = !st_i.sel_end;
          cmd_o.ptr_clr   = !st_i.sel_end;
          cmd_o.flag_clr  = !st_i.sel_end;
          cmd_o.erase_fin = st_i.sel_end;
        end
      end
      S_FWD_CHK: begin
        case (st_i.cmd)
          CMD_PREV: begin
            if (st_i.match) begin
              cmd_o.hnd_rd  = !st_i.ptr_zero;
              cmd_o.hnd_src = HSRC_PREV;
            end else begin
              cmd_o.prev_ld = 1'b1;
              cmd_o.ptr_inc = 1'b1;
            end
          end
          CMD_NEXT: begin
            if (st_i.flag) begin
              cmd_o.hnd_rd  = 1'b1;
              cmd_o.hnd_src = HSRC_ORD;
            end else begin
              cmd_o.flag_upd = 1'b1;
              cmd_o.ptr_inc  = 1'b1;
            end
          end
          default: begin
            cmd_o.ord_wr    = st_i.flag;
            cmd_o.ord_wr_m1 = 1'b1;
            cmd_o.flag_upd  = 1'b1;
            cmd_o.ptr_inc   = 1'b1;
          end
        endcase
      end
      S_NB_DONE: cmd_o.nb_cap = 1'b1;
      S_RESULT:  cmd_o.res_ld = st_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### design/dual_order_sorted_table.sv
// ----------------------------------------------------------------------------
// Dual order sorted table
// Table of handles with begin and end times and short ids, kept in ascending
// begin order and ascending end order, with insert, erase, prev and next.
// ----------------------------------------------------------------------------
// One transaction comes in on the in_valid_i/in_ready_o channel and exactly
// one result transaction leaves on out_valid_o/out_ready_i. The block works
// on one transaction at a time. Every transaction first scans all
// TABLE_DEPTH slots, reading and then checking each one, to find the handle
// and a free slot. Insert then walks each order backward from its end; for
// each entry that moves it reads the position, then the entry's keys, then
// compares and shifts it. Erase walks each order forward, reading and then
// checking each entry. Prev and next walk one order forward until the
// handle is found. A result is held in an output register, so the next
// transaction is accepted while it waits; a stalled receiver only holds
// back the hand-off of the following result. Reset empties the table at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dual_order_sorted_table import dost_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int ID_BYTES    = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dp_cmd_t dp_cmd;
  dp_st_t  dp_st;

  dost_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (dp_st),
    .cmd_o      (dp_cmd)
  );

  dost_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BYTES    (ID_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .st_o        (dp_st),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("A transaction was accepted while another was in progress.");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.res_ld |-> dp_st.out_free)
    else $error("A result was loaded over one not yet taken.");

  a_insert_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.slot_wr |-> !dp_st.full && !dp_st.found)
    else $error("An entry was written into a full table or over a duplicate.");

endmodule
